FILE: design/fhts_pkg.sv
// Shared constants, types and helper functions for the fingerprint hash table store.
`timescale 1ns / 1ps
package fhts_pkg;

   // Table geometry
   localparam int BUCKETS          = 1024;
   localparam int SLOTS            = 8;
   localparam int OVERFLOW_BUCKETS = 128;

   // Derived widths
   localparam int BKT_W    = $clog2(BUCKETS);
   localparam int HALF_BKT = BUCKETS / 2;
   localparam int A_W      = $clog2(HALF_BKT + 1);
   localparam int CFG_BKT_W = 10;
   localparam int CMP_W    = (BKT_W + 1 > CFG_BKT_W + 1) ? BKT_W + 1 : CFG_BKT_W + 1;
   localparam int NROWS    = BUCKETS + OVERFLOW_BUCKETS;
   localparam int ROW_AW   = $clog2(NROWS);
   localparam int NRECS    = NROWS * SLOTS;
   localparam int REC_AW   = $clog2(NRECS);
   localparam int LINK_W   = $clog2(OVERFLOW_BUCKETS + 1);
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_CW  = $clog2(SLOTS + 1);
   localparam int FP_W     = 16;
   localparam int COUNT_W  = 14;
   localparam int DEPTH_W  = 8;

   // Hash constants
   localparam logic [63:0] MUR_M   = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] SEED_BIN = 64'h00000000b9115a39;
   localparam logic [63:0] SEED_FP  = 64'h00000000202a025d;
   localparam logic [15:0] FP_MASK  = 16'hFFFF;

   // Operation and status codes
   localparam logic       OP_GET = 1'b0;
   localparam logic       OP_PUT = 1'b1;
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASE_BUCKETS     = 2'd0;
   localparam logic [1:0] CSR_EXPANDED_BUCKETS = 2'd1;
   localparam logic [1:0] CSR_KEY_BYTES        = 2'd2;
   localparam logic [1:0] CSR_VALUE_BYTES      = 2'd3;

   // Partial product phases of the 64-bit multiplier
   localparam logic [1:0] PART_LL = 2'd0;
   localparam logic [1:0] PART_HL = 2'd1;
   localparam logic [1:0] PART_LH = 2'd2;

   typedef struct packed {
      logic        op;
      logic [63:0] key;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [63:0]        value_out;
      logic [COUNT_W-1:0] record_count;
      logic [DEPTH_W-1:0] deepest_chain;
   } rsp_type;

   // One bucket row: link to overflow plus slot fingerprints
   typedef struct packed {
      logic [LINK_W-1:0]          link;
      logic [SLOTS-1:0][FP_W-1:0] fp;
   } row_type;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] value;
   } rec_type;

   typedef enum logic [1:0] {
      HS_K1,
      HS_K2,
      HS_H1,
      HS_H2
   } hash_step_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_SLOT,
      ST_REC_CMP,
      ST_FILL,
      ST_OVERWRITE,
      ST_ALLOC,
      ST_ALLOC_NEW,
      ST_DONE
   } walk_state_type;

   // Clamp a byte count to 1..8
   function automatic logic [3:0] clamp_bytes(input logic [3:0] b);
      logic [3:0] r;
      r = b;
      if (b == 4'd0) r = 4'd1;
      else if (b > 4'd8) r = 4'd8;
      return r;
   endfunction

   // Mask of the low nb bytes
   function automatic logic [63:0] byte_mask(input logic [3:0] nb);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nb) m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

FILE: design/fhts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module fhts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/fhts_hash.sv
// 64-bit multiply-xorshift key hash built on one 32x32 multiplier, three phases per product.
`timescale 1ns / 1ps
module fhts_hash import fhts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   input  logic [3:0]  len,
   input  logic [63:0] seed,
   output logic        valid,
   output logic [63:0] hash
);

   hash_step_type step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          valid_ff, valid_in;
   logic [1:0]    part_ff, part_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   h0_ff, h0_in;
   logic [63:0]   hash_ff, hash_in;

   logic [31:0]   a32, b32;
   logic [63:0]   pp, acc_sum, mix, h0_calc;
   logic          last_part;

   // Partial product and accumulate
   always_comb begin
      a32 = (part_ff == PART_HL) ? x_ff[63:32] : x_ff[31:0];
      b32 = (part_ff == PART_LH) ? MUR_M[63:32] : MUR_M[31:0];
      pp = 64'(a32) * 64'(b32);
      acc_sum = (part_ff == PART_LL) ? pp : acc_ff + {pp[31:0], 32'd0};
      mix = acc_sum ^ (acc_sum >> 47);
      h0_calc = seed ^ (64'(len) * MUR_M);
      last_part = (part_ff == PART_LH);
   end

   // Next step
   always_comb begin
      step_in = step_ff;
      if (start) begin
         step_in = (len >= 4'd8) ? HS_K1 : HS_H1;
      end else if (busy_ff && last_part) begin
         unique case (step_ff)
            HS_K1:   step_in = HS_K2;
            HS_K2:   step_in = HS_H1;
            HS_H1:   step_in = HS_H2;
            HS_H2:   step_in = HS_H2;
            default: step_in = HS_H2;
         endcase
      end
   end

   // Datapath updates
   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      part_in  = part_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      h0_in    = h0_ff;
      hash_in  = hash_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         part_in  = PART_LL;
         h0_in    = h0_calc;
         x_in     = (len >= 4'd8) ? key : (h0_calc ^ (key & byte_mask(len)));
      end else if (busy_ff) begin
         acc_in = acc_sum;
         if (!last_part) begin
            part_in = part_ff + 2'd1;
         end else begin
            part_in = PART_LL;
            unique case (step_ff)
               HS_K1: x_in = mix;
               HS_K2: x_in = h0_ff ^ acc_sum;
               HS_H1: x_in = mix;
               HS_H2: begin
                  hash_in  = mix;
                  busy_in  = 1'b0;
                  valid_in = 1'b1;
               end
               default: x_in = mix;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         part_ff  <= PART_LL;
         step_ff  <= HS_H1;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         part_ff  <= part_in;
         step_ff  <= step_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      h0_ff   <= h0_in;
      hash_ff <= hash_in;
   end

   assign valid = valid_ff;
   assign hash  = hash_ff;

endmodule

FILE: design/fhts_mod.sv
// Remainder unit: 64-bit value modulo a narrow divisor, four bits per cycle, with quotient LSB.
`timescale 1ns / 1ps
module fhts_mod import fhts_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [63:0]    dividend,
   input  logic [A_W-1:0] divisor,
   output logic           valid,
   output logic [A_W-1:0] rem,
   output logic           q_lsb
);

   localparam int STEP   = 4;
   localparam int ROUNDS = 64 / STEP;
   localparam int CNT_W  = $clog2(ROUNDS + 1);

   logic             busy_ff, busy_in;
   logic             valid_ff, valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      dvd_ff, dvd_in;
   logic [A_W-1:0]   div_ff, div_in;
   logic [A_W-1:0]   rem_ff, rem_in;
   logic             q_ff, q_in;

   logic [A_W:0]     r;
   logic             qb;

   // Four restoring steps on the remainder
   always_comb begin
      r  = {1'b0, rem_ff};
      qb = q_ff;
      for (int i = 0; i < STEP; i++) begin
         r = {r[A_W-1:0], dvd_ff[63-i]};
         if (r >= {1'b0, div_ff}) begin
            r  = r - {1'b0, div_ff};
            qb = 1'b1;
         end else begin
            qb = 1'b0;
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         cnt_in   = '0;
         dvd_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
         q_in     = 1'b0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << STEP;
         rem_in = r[A_W-1:0];
         q_in   = qb;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROUNDS - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign valid = valid_ff;
   assign rem   = rem_ff;
   assign q_lsb = q_ff;

endmodule

FILE: design/fingerprint_hash_table_store_core.sv
// Top level: configuration, bucket selection and the bucket/overflow walk over two RAMs.
//
//  port group | direction | handshake            | payload
//  req_       | in        | start, busy          | req_data  (op, key, value)
//  rsp_       | out       | rsp_strobe (1 cycle) | rsp_data  (status, value_out, count, depth)
//  csr_       | in        | csr_valid, csr_ready | csr_index, csr_data
//
// After reset the row memory is cleared, one row a cycle, for all BUCKETS + OVERFLOW_BUCKETS
// rows; busy is high throughout and configuration writes are still taken.
// One request at a time: the two hashes (two products fewer for keys under eight bytes), run side
// by side at three 32x32 phases per 64-bit product, and the 16-round remainder unit; then
// a read per bucket row, a check per slot plus a record compare per fingerprint hit, then the write.
// The strobed result cannot be stalled; busy falls in the cycle after the strobe.
`timescale 1ns / 1ps
module fingerprint_hash_table_store_core import fhts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [CFG_BKT_W-1:0] csr_data
);

   walk_state_type state_ff, state_in;

   // Configuration
   logic [CFG_BKT_W-1:0] base_ff, exp_ff;
   logic [3:0]           kbytes_ff, vbytes_ff;

   // Per-request registers
   logic                 op_ff, op_in;
   logic [63:0]          key_ff, key_in;
   logic [63:0]          value_ff, value_in;
   logic [63:0]          kmask_ff, kmask_in;
   logic [63:0]          vmask_ff, vmask_in;
   logic [FP_W-1:0]      fp_ff, fp_in;
   logic [ROW_AW-1:0]    cur_row_ff, cur_row_in;
   logic [SLOT_CW-1:0]   slot_ff, slot_in;
   row_type              row_ff, row_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [1:0]           status_ff, status_in;
   logic [63:0]          got_ff, got_in;

   // Table-wide state
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [DEPTH_W-1:0]   maxd_ff, maxd_in;
   logic [LINK_W-1:0]    next_free_ff, next_free_in;
   logic [ROW_AW-1:0]    clr_ff, clr_in;

   // Hash, remainder and memory wiring
   logic                 accept, kb8_start;
   logic [3:0]           kb_now;
   logic                 hb_valid, hf_valid;
   logic [63:0]          hb_hash, hf_hash;
   logic                 mod_start, mod_valid, mod_q;
   logic [A_W-1:0]       mod_rem;
   logic [CMP_W-1:0]     base_x, a_eff, split, r_x, r2_x;
   logic [BKT_W-1:0]     bin;
   logic [63:0]          fold;
   logic [FP_W-1:0]      fp_calc;

   logic                 row_wr_en, row_rd_en;
   logic [ROW_AW-1:0]    row_wr_addr;
   row_type              row_wr_data, row_rd_data, row_fill, row_tail, row_new;
   logic                 rec_wr_en, rec_rd_en;
   logic [REC_AW-1:0]    rec_wr_addr, rec_rd_addr, rec_cur_addr, rec_new_addr;
   rec_type              rec_wr_data, rec_rd_data;
   logic [ROW_AW-1:0]    new_row, link_row;
   logic [SLOT_W-1:0]    slot_idx;
   logic [FP_W-1:0]      slot_fp;
   logic                 slot_end, key_hit, ovf_full;
   logic [DEPTH_W-1:0]   depth_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign kb_now    = clamp_bytes(kbytes_ff);
   assign kb8_start = accept;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= CFG_BKT_W'(512);
         exp_ff    <= CFG_BKT_W'(512);
         kbytes_ff <= 4'd8;
         vbytes_ff <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BASE_BUCKETS:     base_ff   <= csr_data;
            CSR_EXPANDED_BUCKETS: exp_ff    <= csr_data;
            CSR_KEY_BYTES:        kbytes_ff <= csr_data[3:0];
            CSR_VALUE_BYTES:      vbytes_ff <= csr_data[3:0];
         endcase
      end
   end

   // Bucket hash and fingerprint hash run side by side
   fhts_hash u_hash_bin (
      .clock (clock),
      .reset (reset),
      .start (kb8_start),
      .key   (req_data.key),
      .len   (kb_now),
      .seed  (SEED_BIN),
      .valid (hb_valid),
      .hash  (hb_hash)
   );

   fhts_hash u_hash_fp (
      .clock (clock),
      .reset (reset),
      .start (kb8_start),
      .key   (req_data.key),
      .len   (kb_now),
      .seed  (SEED_FP),
      .valid (hf_valid),
      .hash  (hf_hash)
   );

   // Clamp the base size and fold the fingerprint
   always_comb begin
      base_x = CMP_W'(base_ff);
      if (base_x == '0) a_eff = CMP_W'(1);
      else if (base_x > CMP_W'(HALF_BKT)) a_eff = CMP_W'(HALF_BKT);
      else a_eff = base_x;
      split = (CMP_W'(exp_ff) > a_eff) ? CMP_W'(exp_ff) - a_eff : '0;
      fold = hf_hash ^ (hf_hash >> 16) ^ (hf_hash >> 32) ^ (hf_hash >> 48);
      fp_calc = (fold[FP_W-1:0] & FP_MASK) == '0 ? FP_W'(1) : (fold[FP_W-1:0] & FP_MASK);
   end

   assign mod_start = (state_ff == ST_HASH) && hb_valid && hf_valid;

   fhts_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (hb_hash),
      .divisor  (a_eff[A_W-1:0]),
      .valid    (mod_valid),
      .rem      (mod_rem),
      .q_lsb    (mod_q)
   );

   // Pick the bucket: the odd quotient moves the double-size remainder up by base
   always_comb begin
      r_x  = CMP_W'(mod_rem);
      r2_x = mod_q ? r_x + a_eff : r_x;
      bin  = (r_x < split) ? r2_x[BKT_W-1:0] : r_x[BKT_W-1:0];
   end

   // Slot and address helpers
   always_comb begin
      slot_idx     = slot_ff[SLOT_W-1:0];
      slot_end     = (slot_ff == SLOT_CW'(SLOTS));
      slot_fp      = row_ff.fp[slot_idx];
      key_hit      = ((rec_rd_data.key ^ key_ff) & kmask_ff) == '0;
      ovf_full     = (next_free_ff == LINK_W'(OVERFLOW_BUCKETS));
      new_row      = ROW_AW'(BUCKETS) + ROW_AW'(next_free_ff);
      link_row     = ROW_AW'(BUCKETS) + ROW_AW'(row_ff.link - LINK_W'(1));
      rec_cur_addr = REC_AW'(cur_row_ff) * REC_AW'(SLOTS) + REC_AW'(slot_ff);
      rec_new_addr = REC_AW'(new_row) * REC_AW'(SLOTS);
      depth_next   = (depth_ff == '1) ? depth_ff : depth_ff + DEPTH_W'(1);
      row_fill     = row_ff;
      row_fill.fp[slot_idx] = fp_ff;
      row_tail     = row_ff;
      row_tail.link = next_free_ff + LINK_W'(1);
      row_new      = '0;
      row_new.fp[0] = fp_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_ff == ROW_AW'(NROWS - 1)) state_in = ST_IDLE;
         ST_IDLE:      if (start) state_in = ST_HASH;
         ST_HASH:      if (hb_valid && hf_valid) state_in = ST_MOD;
         ST_MOD:       if (mod_valid) state_in = ST_ROW_RD;
         ST_ROW_RD:    state_in = ST_ROW_WAIT;
         ST_ROW_WAIT:  state_in = ST_SLOT;
         ST_SLOT: begin
            if (slot_end) begin
               if (row_ff.link != '0) state_in = ST_ROW_RD;
               else if (op_ff == OP_PUT) state_in = ST_ALLOC;
               else state_in = ST_DONE;
            end else if (slot_fp == '0) begin
               state_in = (op_ff == OP_PUT) ? ST_FILL : ST_DONE;
            end else if (slot_fp == fp_ff) begin
               state_in = ST_REC_CMP;
            end
         end
         ST_REC_CMP: begin
            if (key_hit) state_in = (op_ff == OP_PUT) ? ST_OVERWRITE : ST_DONE;
            else state_in = ST_SLOT;
         end
         ST_FILL:      state_in = ST_DONE;
         ST_OVERWRITE: state_in = ST_DONE;
         ST_ALLOC:     state_in = ovf_full ? ST_DONE : ST_ALLOC_NEW;
         ST_ALLOC_NEW: state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs and register updates
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      kmask_in     = kmask_ff;
      vmask_in     = vmask_ff;
      fp_in        = fp_ff;
      cur_row_in   = cur_row_ff;
      slot_in      = slot_ff;
      row_in       = row_ff;
      depth_in     = depth_ff;
      status_in    = status_ff;
      got_in       = got_ff;
      count_in     = count_ff;
      maxd_in      = maxd_ff;
      next_free_in = next_free_ff;
      clr_in       = clr_ff;
      row_wr_en    = 1'b0;
      row_wr_addr  = cur_row_ff;
      row_wr_data  = row_fill;
      row_rd_en    = 1'b0;
      rec_wr_en    = 1'b0;
      rec_wr_addr  = rec_cur_addr;
      rec_wr_data  = '{key: key_ff, value: value_ff};
      rec_rd_en    = 1'b0;
      rec_rd_addr  = rec_cur_addr;
      rsp_strobe   = 1'b0;
      unique case (state_ff)
         // Sweep zero rows through the row memory
         ST_CLEAR: begin
            row_wr_en   = 1'b1;
            row_wr_addr = clr_ff;
            row_wr_data = '0;
            clr_in      = clr_ff + ROW_AW'(1);
         end
         // Latch the request
         ST_IDLE: begin
            if (start) begin
               op_in     = req_data.op;
               key_in    = req_data.key;
               value_in  = req_data.value;
               kmask_in  = byte_mask(kb_now);
               vmask_in  = byte_mask(clamp_bytes(vbytes_ff));
               depth_in  = '0;
               got_in    = '0;
               status_in = STATUS_NOT_FOUND;
            end
         end
         ST_HASH: begin
            if (hb_valid && hf_valid) fp_in = fp_calc;
         end
         ST_MOD: begin
            if (mod_valid) cur_row_in = ROW_AW'(bin);
         end
         ST_ROW_RD: begin
            row_rd_en = 1'b1;
         end
         ST_ROW_WAIT: begin
            row_in  = row_rd_data;
            slot_in = '0;
         end
         // Walk one slot, or follow the link at the end of the row
         ST_SLOT: begin
            if (slot_end) begin
               if (row_ff.link != '0) begin
                  cur_row_in = link_row;
                  depth_in   = depth_next;
                  if (depth_next > maxd_ff) maxd_in = depth_next;
               end
            end else if (slot_fp == '0) begin
               status_in = (op_ff == OP_PUT) ? STATUS_OK : STATUS_NOT_FOUND;
            end else if (slot_fp == fp_ff) begin
               rec_rd_en = 1'b1;
            end else begin
               slot_in = slot_ff + SLOT_CW'(1);
            end
         end
         ST_REC_CMP: begin
            if (key_hit) begin
               status_in = STATUS_OK;
               if (op_ff == OP_GET) got_in = rec_rd_data.value & vmask_ff;
            end else begin
               slot_in = slot_ff + SLOT_CW'(1);
            end
         end
         // Place a new record in the first empty slot
         ST_FILL: begin
            row_wr_en = 1'b1;
            rec_wr_en = 1'b1;
            count_in  = count_ff + COUNT_W'(1);
         end
         ST_OVERWRITE: begin
            rec_wr_en = 1'b1;
         end
         // Link the next free overflow bucket to the tail, or report full when none is left
         ST_ALLOC: begin
            if (ovf_full) begin
               status_in = STATUS_FULL;
            end else begin
               row_wr_en   = 1'b1;
               row_wr_data = row_tail;
            end
         end
         ST_ALLOC_NEW: begin
            row_wr_en    = 1'b1;
            row_wr_addr  = new_row;
            row_wr_data  = row_new;
            rec_wr_en    = 1'b1;
            rec_wr_addr  = rec_new_addr;
            next_free_in = next_free_ff + LINK_W'(1);
            count_in     = count_ff + COUNT_W'(1);
            depth_in     = depth_next;
            if (depth_next > maxd_ff) maxd_in = depth_next;
            status_in    = STATUS_OK;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            rsp_strobe = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         maxd_ff      <= '0;
         next_free_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         maxd_ff      <= maxd_in;
         next_free_ff <= next_free_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      kmask_ff   <= kmask_in;
      vmask_ff   <= vmask_in;
      fp_ff      <= fp_in;
      cur_row_ff <= cur_row_in;
      slot_ff    <= slot_in;
      row_ff     <= row_in;
      depth_ff   <= depth_in;
      status_ff  <= status_in;
      got_ff     <= got_in;
   end

   // Result fields
   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.value_out     = got_ff;
      rsp_data.record_count  = count_ff;
      rsp_data.deepest_chain = maxd_ff;
   end

   // Bucket rows with links, and records
   fhts_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (NROWS)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (row_rd_en),
      .rd_addr (cur_row_ff),
      .rd_data (row_rd_data)
   );

   fhts_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (NRECS)
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_en   (rec_rd_en),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   // A result strobe lasts one cycle and the block is free right after
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   // Chains only use allocated overflow buckets
   assert property (@(posedge clock) disable iff (reset)
      maxd_ff <= DEPTH_W'(next_free_ff))
      else $error("chain depth beyond allocated overflow buckets");

   // The allocation pointer never runs past the overflow area
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= LINK_W'(OVERFLOW_BUCKETS))
      else $error("overflow allocation pointer out of range");

   // A full overflow area leaves the record count alone
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC && ovf_full) |=> $stable(count_ff))
      else $error("record count changed on full overflow area");

   // The record count grows by at most one per request
   assert property (@(posedge clock) disable iff (reset)
      count_ff == $past(count_ff) || count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("record count jumped");

endmodule
